// ===== hw/rtl/atpq_pkg.sv =====
// Shared widths, register indexes, reset values and control types of the position quantizer.
`default_nettype none

package atpq_pkg;

  localparam int READ_W = 11;
  localparam int POS_W = 6;
  localparam int FRAC_W = 16;
  localparam int DVD_W = READ_W + FRAC_W;

  localparam int POSITIONS_DEFAULT = 48;
  localparam int TOLERANCE_DEFAULT = 3;

  localparam int REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_ENDSTOP_ZERO = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_ENDSTOP_FAR = 1'b1;

  localparam logic [READ_W-1:0] ENDSTOP_ZERO_RESET = 11'd1726;
  localparam logic [READ_W-1:0] ENDSTOP_FAR_RESET = 11'd352;

  typedef struct packed {
    logic build_start;
    logic fill_run;
    logic take;
    logic reject;
    logic walk_run;
    logic load_result;
  } cmd_t;

  typedef struct packed {
    logic fill_done;
    logic in_range;
    logic walk_done;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/atpq_in_if.sv =====
// Input channel: one doubled potentiometer reading per word.
`default_nettype none

interface atpq_in_if
  import atpq_pkg::*;
;
  logic valid;
  logic ready;
  logic [READ_W-1:0] doubled_reading;

  modport source (output valid, output doubled_reading, input ready);
  modport sink (input valid, input doubled_reading, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/atpq_out_if.sv =====
// Output channel: one valve position and its valid flag per word.
`default_nettype none

interface atpq_out_if
  import atpq_pkg::*;
;
  logic valid;
  logic ready;
  logic [POS_W-1:0] position;
  logic position_valid;

  modport source (output valid, output position, output position_valid, input ready);
  modport sink (input valid, input position, input position_valid, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/atpq_ram.sv =====
// Generic simple dual-port RAM with registered read.
`default_nettype none

module atpq_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 49
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/atpq_ctrl.sv =====
// Controller: table rebuild sequence and per-word lookup sequence.
`default_nettype none

module atpq_ctrl
  import atpq_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    cfg_write,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire status_t status,
  output cmd_t         cmd
);

  localparam logic [2:0] S_START = 3'd0;
  localparam logic [2:0] S_FILL  = 3'd1;
  localparam logic [2:0] S_IDLE  = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_WALK  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == S_IDLE) && !cfg_write;

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      S_START: begin
        cmd.build_start = 1'b1;
        state_next = S_FILL;
      end
      S_FILL: begin
        cmd.fill_run = 1'b1;
        if (status.fill_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.take = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status.in_range) begin
          state_next = S_WALK;
        end else begin
          cmd.reject = 1'b1;
          state_next = S_DONE;
        end
      end
      S_WALK: begin
        cmd.walk_run = 1'b1;
        if (status.walk_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.load_result = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_START;
      end
    endcase
    // restart the rebuild on any register write
    if (cfg_write) begin
      state_next = S_START;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_START;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/atpq_dp.sv =====
// Datapath: endstop registers, step multiplier, table fill, table walk and output register.
`default_nettype none

module atpq_dp
  import atpq_pkg::*;
#(
  parameter int POSITIONS = POSITIONS_DEFAULT,
  parameter int TOLERANCE = TOLERANCE_DEFAULT
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_write,
  input  wire logic [REG_IDX_W-1:0] cfg_index,
  input  wire logic [READ_W-1:0]    cfg_data,
  input  wire cmd_t                 cmd,
  output status_t                   status,
  input  wire logic [READ_W-1:0]    doubled_reading,
  input  wire logic                 out_ready,
  output logic                      out_valid,
  output logic [POS_W-1:0]          position,
  output logic                      position_valid
);

  localparam int IDX_W = $clog2(POSITIONS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POSITIONS);
  localparam logic [IDX_W:0] LAST_POS = (IDX_W + 1)'(POSITIONS);
  localparam logic [READ_W:0] TOL = (READ_W + 1)'(TOLERANCE);

  // reciprocal of POSITIONS, exact for every dividend of DVD_W bits
  localparam int STEP_SH = DVD_W + IDX_W;
  localparam int RECIP_W = DVD_W + 2;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << STEP_SH) + 64'(POSITIONS - 1)) / 64'(POSITIONS));
  localparam int PROD_W = READ_W + RECIP_W;
  localparam int STEP_LSB = STEP_SH - FRAC_W;

  logic [READ_W-1:0] endstop_zero;
  logic [READ_W-1:0] endstop_far;

  logic [DVD_W-1:0]  step;
  logic [DVD_W-1:0]  acc;
  logic [IDX_W-1:0]  fidx;
  logic [READ_W-1:0] t_first;
  logic [READ_W-1:0] t_last;

  logic [READ_W-1:0] reading;
  logic [IDX_W-1:0]  widx;
  logic [IDX_W-1:0]  cmp_idx;
  logic              cmp_valid;
  logic [READ_W-1:0] prev;
  logic [IDX_W:0]    res_pos;
  logic              res_found;

  logic [READ_W-1:0] diff;
  logic [PROD_W-1:0] step_prod;
  logic [READ_W-1:0] cur;
  logic [READ_W-1:0] half;
  logic              hit_eq;
  logic              hit_lt;
  logic              decide;
  logic [IDX_W:0]    pos_raw;
  logic [IDX_W:0]    pos_clamped;
  logic [IDX_W+POS_W:0] pos_ext;

  atpq_ram #(
    .WIDTH(READ_W),
    .DEPTH(POSITIONS + 1)
  ) u_table (
    .clk  (clk),
    .we   (cmd.fill_run),
    .waddr(fidx),
    .wdata(acc[DVD_W-1:FRAC_W]),
    .raddr(widx),
    .rdata(cur)
  );

  assign diff = (endstop_zero > endstop_far) ? (endstop_zero - endstop_far) : '0;
  assign step_prod = PROD_W'(diff) * PROD_W'(RECIP);

  assign half = (cur >= prev) ? ((cur - prev) >> 1) : '0;
  assign hit_eq = reading == cur;
  assign hit_lt = reading < cur;
  assign decide = hit_eq || hit_lt;

  always_comb begin
    if (hit_eq) begin
      pos_raw = {1'b0, cmp_idx};
    end else if ((cur - half) >= reading) begin
      pos_raw = {1'b0, cmp_idx} + (IDX_W + 1)'(1);
    end else begin
      pos_raw = {1'b0, cmp_idx};
    end
    pos_clamped = (pos_raw > LAST_POS) ? LAST_POS : pos_raw;
  end

  assign pos_ext = {{POS_W{1'b0}}, res_pos};

  assign status.fill_done = fidx == '0;
  assign status.in_range = (({1'b0, reading} + TOL) >= {1'b0, t_last})
                        && ({1'b0, reading} <= ({1'b0, t_first} + TOL));
  assign status.walk_done = cmp_valid && (decide || (cmp_idx == '0));
  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      endstop_zero <= ENDSTOP_ZERO_RESET;
      endstop_far <= ENDSTOP_FAR_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ENDSTOP_ZERO: endstop_zero <= cfg_data;
        REG_ENDSTOP_FAR:  endstop_far <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.build_start) begin
      step <= DVD_W'(step_prod[PROD_W-1:STEP_LSB]);
      acc <= {endstop_far, {FRAC_W{1'b0}}};
      fidx <= LAST_IDX;
    end
    if (cmd.fill_run) begin
      acc <= acc + step;
      fidx <= fidx - IDX_W'(1);
      if (fidx == LAST_IDX) begin
        t_last <= acc[DVD_W-1:FRAC_W];
      end
      if (fidx == '0) begin
        t_first <= acc[DVD_W-1:FRAC_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_valid <= 1'b0;
    end else if (cmd.take) begin
      cmp_valid <= 1'b0;
    end else if (cmd.walk_run) begin
      cmp_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      reading <= doubled_reading;
      widx <= LAST_IDX;
      prev <= t_last;
    end
    if (cmd.reject) begin
      res_pos <= '0;
      res_found <= 1'b0;
    end
    if (cmd.walk_run) begin
      cmp_idx <= widx;
      widx <= (widx == '0) ? '0 : (widx - IDX_W'(1));
      if (cmp_valid) begin
        prev <= cur;
        if (decide) begin
          res_pos <= pos_clamped;
          res_found <= 1'b1;
        end else if (cmp_idx == '0) begin
          res_pos <= '0;
          res_found <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_result) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      position <= pos_ext[POS_W-1:0];
      position_valid <= res_found;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/adc_to_position_quantizer.sv =====
// Top level: potentiometer reading to valve position quantizer.
//
//   channel   direction  word
//   reading   in         doubled_reading[10:0]
//   result    out        position[5:0], position_valid
//   cfg       in         cfg_index[0], cfg_data[10:0], write on cfg_write
//
// After reset and after every register write the table is rebuilt: the step is formed,
// then POSITIONS+1 table entries are filled; reading.ready is low meanwhile.
// An out-of-range reading is rejected after the range check; otherwise the table walk
// sets the result, one RAM read per entry from the far end.
// The result waits in an output register; the next reading is taken while it stalls.
`default_nettype none

module adc_to_position_quantizer
  import atpq_pkg::*;
#(
  parameter int POSITIONS = POSITIONS_DEFAULT,
  parameter int TOLERANCE = TOLERANCE_DEFAULT
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  atpq_in_if.sink                   reading,
  atpq_out_if.source                result,
  input  wire logic                 cfg_write,
  input  wire logic [REG_IDX_W-1:0] cfg_index,
  input  wire logic [READ_W-1:0]    cfg_data
);

  cmd_t    cmd;
  status_t status;

  atpq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .in_valid (reading.valid),
    .in_ready (reading.ready),
    .status   (status),
    .cmd      (cmd)
  );

  atpq_dp #(
    .POSITIONS(POSITIONS),
    .TOLERANCE(TOLERANCE)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .cmd            (cmd),
    .status         (status),
    .doubled_reading(reading.doubled_reading),
    .out_ready      (result.ready),
    .out_valid      (result.valid),
    .position       (result.position),
    .position_valid (result.position_valid)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/atpq_checker.sv =====
// Port-level assertions for the quantizer and their bind to the top level.
`default_nettype none

module atpq_checker
  import atpq_pkg::*;
#(
  parameter int POSITIONS = POSITIONS_DEFAULT
) (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             in_valid,
  input wire logic             in_ready,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic [POS_W-1:0] position,
  input wire logic             position_valid
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(position) && $stable(position_valid))
    else $error("stalled result word changed");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !position_valid |-> position == '0)
    else $error("not-found result carries a nonzero position");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> int'(position) <= POSITIONS)
    else $error("position beyond the far endstop");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("reading taken while a lookup is in progress");

endmodule

bind adc_to_position_quantizer atpq_checker #(
  .POSITIONS(POSITIONS)
) u_atpq_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (reading.valid),
  .in_ready      (reading.ready),
  .out_valid     (result.valid),
  .out_ready     (result.ready),
  .position      (result.position),
  .position_valid(result.position_valid)
);

`default_nettype wire
